@@ rtl/psdat_pkg.sv @@
// Shared types and constants for the partial S-box difference-table tracker.
package psdat_pkg;

    localparam int SBOX_BITS_DEF = 8;
    localparam int COUNT_W       = 2;
    localparam logic [COUNT_W-1:0] COUNT_MAX = 2'd3;
    localparam logic [COUNT_W-1:0] COUNT_ONE = 2'd1;
    localparam logic [COUNT_W-1:0] COUNT_ZERO = 2'd0;

    typedef enum logic [1:0] {
        REQ_CLEAR  = 2'd0,
        REQ_ADD    = 2'd1,
        REQ_REMOVE = 2'd2
    } t_req;

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_LOAD,
        S_WALK,
        S_DRAIN_A,
        S_DRAIN_B,
        S_FINISH
    } t_state;

    // Control from the sequencer to the count unit.
    typedef struct packed {
        logic lookup;
        logic is_add;
        logic halt;
        logic clr;
    } t_cnt_ctl;

    // Events reported by the count unit with each write-back.
    typedef struct packed {
        logic stop;
        logic fail;
    } t_cnt_sts;

endpackage

@@ rtl/psdat_cnt_unit.sv @@
// Pair-count memory with its read-modify-write stage and clear port.
module psdat_cnt_unit
    import psdat_pkg::*;
#(
    parameter int SBOX_BITS = SBOX_BITS_DEF
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  t_cnt_ctl               i_ctl,
    input  logic [2*SBOX_BITS-1:0] i_idx,
    input  logic [2*SBOX_BITS-1:0] i_clr_idx,
    output t_cnt_sts               o_sts
);

    localparam int IW    = 2 * SBOX_BITS;
    localparam int DEPTH = 1 << IW;

    logic [COUNT_W-1:0] r_mem [DEPTH];
    logic [COUNT_W-1:0] r_q;
    logic [IW-1:0]      r_idx;
    logic               r_lk_vld;
    logic [COUNT_W-1:0] n_cnt;
    logic               wen;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_lk_vld <= 1'b0;
        end else begin
            r_lk_vld <= i_ctl.lookup;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.lookup) begin
            r_q   <= r_mem[i_idx];
            r_idx <= i_idx;
        end
    end

    // Saturating increment for add, floored decrement for remove.
    always_comb begin
        if (i_ctl.is_add) begin
            n_cnt = (r_q == COUNT_MAX) ? r_q : r_q + COUNT_ONE;
        end else begin
            n_cnt = (r_q == COUNT_ZERO) ? r_q : r_q - COUNT_ONE;
        end
    end

    assign wen = r_lk_vld && !i_ctl.halt;

    always_ff @(posedge i_clk) begin
        if (i_ctl.clr) begin
            r_mem[i_clr_idx] <= COUNT_ZERO;
        end else if (wen) begin
            r_mem[r_idx] <= n_cnt;
        end
    end

    assign o_sts.fail = wen && i_ctl.is_add && (n_cnt > COUNT_ONE);
    assign o_sts.stop = wen && (i_ctl.is_add ? (n_cnt > COUNT_ONE) : (n_cnt == COUNT_ONE));

endmodule

@@ rtl/partial_sbox_ddt_apn_tracker.sv @@
// Top level of the partial S-box difference-table tracker with APN check.
//
// Usage: requests enter on i_valid/o_stall with fields i_req_type, i_position
// and i_value; a request is taken at an edge where i_valid is high and o_stall
// is low. Every request gives exactly one result on o_valid/i_stall, carrying
// o_admissible. One request is worked on at a time.
// An add or remove first fetches the stored value, then issues each nonzero
// even-weight difference in turn into the three-stage S-box read, count read,
// count write-back pipeline, drains it and loads the output register. The
// next request can be taken once the result is loaded, so the walk of one
// request is through before the next is taken. A remove of an unset position
// goes from the fetch straight to the output register, an unknown request
// straight from acceptance.
// A clear sweeps the count memory one entry per cycle over all 2^(2*SBOX_BITS)
// entries (65536 for 8 bits); its result is loaded into the output register
// after the sweep. After reset the same sweep runs with o_stall high; the S-box
// valid bits clear at once. A finished result waits in an output register
// while i_stall is high; the next request may be accepted meanwhile, but its
// result is held back until the register is free.
module partial_sbox_ddt_apn_tracker
    import psdat_pkg::*;
#(
    parameter int SBOX_BITS = SBOX_BITS_DEF
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_valid,
    output logic       o_stall,
    input  logic [1:0] i_req_type,
    input  logic [7:0] i_position,
    input  logic [7:0] i_value,
    output logic       o_valid,
    input  logic       i_stall,
    output logic       o_admissible
);

    localparam int SBOX_SIZE = 1 << SBOX_BITS;
    localparam int KW        = SBOX_BITS - 1;
    localparam int IW        = 2 * SBOX_BITS;

    t_state r_state, n_state;

    t_req                 r_req;
    logic [SBOX_BITS-1:0] r_pos;
    logic [SBOX_BITS-1:0] r_val;
    logic                 r_fail;
    logic                 r_stop;
    logic                 r_init;
    logic [KW-1:0]        r_k;
    logic [IW-1:0]        r_clr_cnt;
    logic [SBOX_SIZE-1:0] r_sb_vld;
    logic [SBOX_BITS-1:0] r_sb_mem [SBOX_SIZE];
    logic [SBOX_BITS-1:0] r_sb_rd;
    logic                 r_a_hit;
    logic [SBOX_BITS-1:0] r_a_d;
    logic                 r_out_vld;
    logic                 r_out_adm;

    logic                 accept;
    logic                 issue;
    logic                 clr_en;
    logic                 fin_take;
    logic [SBOX_BITS-1:0] walk_d;
    logic [SBOX_BITS-1:0] partner;
    logic [SBOX_BITS-1:0] sb_rd_addr;
    logic [SBOX_BITS-1:0] in_pos;
    logic [SBOX_BITS-1:0] in_val;
    t_req                 in_req;
    t_cnt_ctl             cnt_ctl;
    t_cnt_sts             cnt_sts;
    logic [IW-1:0]        cnt_idx;

    assign in_pos = i_position[SBOX_BITS-1:0];
    assign in_val = i_value[SBOX_BITS-1:0];
    assign in_req = t_req'(i_req_type);
    assign accept = i_valid && !o_stall;

    // The even-weight differences in ascending order are the counter value
    // shifted up by one with its parity appended as the low bit.
    assign walk_d     = {r_k, ^r_k};
    assign partner    = r_pos ^ walk_d;
    assign sb_rd_addr = (r_state == S_WALK) ? partner : in_pos;

    // Next state.
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_CLEAR: begin
                if (r_clr_cnt == {IW{1'b1}}) begin
                    n_state = r_init ? S_IDLE : S_FINISH;
                end
            end
            S_IDLE: begin
                if (accept) begin
                    case (in_req)
                        REQ_CLEAR:  n_state = S_CLEAR;
                        REQ_ADD:    n_state = S_LOAD;
                        REQ_REMOVE: n_state = S_LOAD;
                        default:    n_state = S_FINISH;
                    endcase
                end
            end
            S_LOAD: begin
                if (r_req == REQ_REMOVE && !r_sb_vld[r_pos]) begin
                    n_state = S_FINISH;
                end else begin
                    n_state = S_WALK;
                end
            end
            S_WALK: begin
                if (r_k == {KW{1'b1}}) begin
                    n_state = S_DRAIN_A;
                end
            end
            S_DRAIN_A: n_state = S_DRAIN_B;
            S_DRAIN_B: n_state = S_FINISH;
            S_FINISH: begin
                if (!r_out_vld || !i_stall) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // Control outputs of the sequencer.
    always_comb begin
        o_stall  = (r_state != S_IDLE) || !i_rst_n;
        issue    = (r_state == S_WALK);
        clr_en   = (r_state == S_CLEAR);
        fin_take = (r_state == S_FINISH) && (!r_out_vld || !i_stall);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_CLEAR;
            r_init    <= 1'b1;
            r_clr_cnt <= '0;
            r_sb_vld  <= '0;
            r_a_hit   <= 1'b0;
            r_stop    <= 1'b0;
            r_fail    <= 1'b0;
            r_out_vld <= 1'b0;
        end else begin
            r_state <= n_state;

            if (clr_en) begin
                r_clr_cnt <= r_clr_cnt + 1'b1;
                if (r_clr_cnt == {IW{1'b1}}) begin
                    r_init <= 1'b0;
                end
            end

            if (accept) begin
                r_stop <= 1'b0;
                r_fail <= 1'b0;
                if (in_req == REQ_CLEAR) begin
                    r_sb_vld  <= '0;
                    r_clr_cnt <= '0;
                end else if (in_req == REQ_ADD) begin
                    r_sb_vld[in_pos] <= 1'b1;
                end
            end else begin
                if (cnt_sts.stop) begin
                    r_stop <= 1'b1;
                end
                if (cnt_sts.fail) begin
                    r_fail <= 1'b1;
                end
            end

            // A remove unsets its position once the walk is done.
            if (r_state == S_FINISH && r_req == REQ_REMOVE) begin
                r_sb_vld[r_pos] <= 1'b0;
            end

            r_a_hit <= issue && r_sb_vld[partner];

            if (fin_take) begin
                r_out_vld <= 1'b1;
            end else if (r_out_vld && !i_stall) begin
                r_out_vld <= 1'b0;
            end
        end
    end

    // Request payload, walk counter and stage registers.
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_req <= in_req;
            r_pos <= in_pos;
            r_val <= in_val;
        end
        if (r_state == S_LOAD) begin
            r_k <= {{(KW-1){1'b0}}, 1'b1};
            if (r_req == REQ_REMOVE) begin
                r_val <= r_sb_rd;
            end
        end else if (issue) begin
            r_k <= r_k + 1'b1;
        end
        r_a_d <= walk_d;
        if (fin_take) begin
            r_out_adm <= !r_fail;
        end
    end

    // S-box value memory: written by an add, read at the request position
    // while idle and at the partner position during the walk.
    always_ff @(posedge i_clk) begin
        if (accept && in_req == REQ_ADD) begin
            r_sb_mem[in_pos] <= in_val;
        end
        r_sb_rd <= r_sb_mem[sb_rd_addr];
    end

    // The count index holds the input difference, so no two steps of one
    // walk touch the same entry and the pipeline needs no forwarding.
    assign cnt_idx = {r_a_d, r_val ^ r_sb_rd};

    always_comb begin
        cnt_ctl.lookup = r_a_hit;
        cnt_ctl.is_add = (r_req == REQ_ADD);
        cnt_ctl.halt   = r_stop;
        cnt_ctl.clr    = clr_en;
    end

    psdat_cnt_unit #(
        .SBOX_BITS (SBOX_BITS)
    ) u_cnt (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_ctl     (cnt_ctl),
        .i_idx     (cnt_idx),
        .i_clr_idx (r_clr_cnt),
        .o_sts     (cnt_sts)
    );

    assign o_valid      = r_out_vld;
    assign o_admissible = r_out_adm;

endmodule
